// ----- design/dire_pkg.sv -----
// dire_pkg: constants, register indexes and arithmetic helpers shared by
// the delayed ikeda reservoir euler step unit and its checker
// depends on nothing
package dire_pkg;

  localparam int NUM_LANES   = 4;
  localparam int NUM_LINES   = 2;
  localparam int RING_DEPTH  = 4096;
  localparam int LANE_W      = $clog2(NUM_LANES);
  localparam int LINE_W      = 1;
  localparam int PTR_W       = $clog2(RING_DEPTH);
  localparam int LEN_W       = 13;
  localparam int ADDR_W      = LANE_W + LINE_W + PTR_W;
  localparam int RING_WORDS  = NUM_LANES * NUM_LINES * RING_DEPTH;

  localparam logic [26:0] PI_Q24     = 27'd52707179;
  // pi shifted left 14, keeps every sine argument non-negative
  localparam logic [42:0] PI_SHIFTED = 43'd863554420736;
  // 2^57 / PI_Q24, reciprocal for the modulo and the segment scaling
  localparam logic [31:0] RECIP_PI   = 32'((64'd1 << 57) / 64'(PI_Q24));

  localparam logic [2:0] REG_FEEDBACK_GAIN = 3'd0;
  localparam logic [2:0] REG_DAMPING       = 3'd1;
  localparam logic [2:0] REG_PHASE_OFFSET  = 3'd2;
  localparam logic [2:0] REG_INPUT_SCALE   = 3'd3;
  localparam logic [2:0] REG_STEP_SIZE     = 3'd4;
  localparam logic [2:0] REG_DELAY_LEN_0   = 3'd5;
  localparam logic [2:0] REG_DELAY_LEN_1   = 3'd6;

  localparam logic REQ_STEP = 1'b0;
  localparam logic REQ_INIT = 1'b1;

  // quarter wave sine, index 0..32, mirrored past 16
  function automatic logic [24:0] sine_at(input logic [5:0] k);
    logic [4:0] m;
    m = (k <= 6'd16) ? k[4:0] : 5'(6'd32 - k);
    case (m)
      5'd0:    return 25'd0;
      5'd1:    return 25'd1644455;
      5'd2:    return 25'd3273072;
      5'd3:    return 25'd4870169;
      5'd4:    return 25'd6420363;
      5'd5:    return 25'd7908725;
      5'd6:    return 25'd9320922;
      5'd7:    return 25'd10643353;
      5'd8:    return 25'd11863283;
      5'd9:    return 25'd12968963;
      5'd10:   return 25'd13949745;
      5'd11:   return 25'd14796184;
      5'd12:   return 25'd15500126;
      5'd13:   return 25'd16054795;
      5'd14:   return 25'd16454847;
      5'd15:   return 25'd16696429;
      default: return 25'd16777216;
    endcase
  endfunction

  // product back to q8.24, round half up
  function automatic logic signed [41:0] rnd24(input logic signed [65:0] p);
    logic signed [65:0] t;
    t = p + 66'sd8388608;
    return t[65:24];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
    if (v > 44'sd2147483647) return 32'h7fffffff;
    if (v < -44'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

endpackage

// ----- design/delayed_ikeda_reservoir_euler_step_unit.sv -----
// delayed_ikeda_reservoir_euler_step_unit: four lane delay coupled ikeda
// node, one euler step per word, one shared multiplier
// depends on dire_pkg
//
// channel  dir  handshake            payload
// cfg      in   wr_en                wr_index, wr_data
// in       in   in_valid / in_stall  req_type, val_a_0..3, val_b_0..3
// out      out  out_valid / out_stall x_out_0..3, y_out_0..3
//
// a step word runs the four lanes in turn: per lane, two sine arguments,
// one per delay line, each reduced modulo pi and scaled to a table segment
// by four products, two by the reciprocal of pi, on the 33x33 multiplier
// shared by every product. the next word can be taken as the result appears.
// rst is synchronous: lanes, pointers, fill counts and registers clear.
// the ring memory is not cleared; entries past a line's fill count read as
// the lane's init value. a stalled result holds while the next word runs.
module delayed_ikeda_reservoir_euler_step_unit
  import dire_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [31:0]        wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  logic signed [31:0] val_a_0,
  input  logic signed [31:0] val_a_1,
  input  logic signed [31:0] val_a_2,
  input  logic signed [31:0] val_a_3,
  input  logic signed [31:0] val_b_0,
  input  logic signed [31:0] val_b_1,
  input  logic signed [31:0] val_b_2,
  input  logic signed [31:0] val_b_3,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] x_out_0,
  output logic signed [31:0] x_out_1,
  output logic signed [31:0] x_out_2,
  output logic signed [31:0] x_out_3,
  output logic signed [31:0] y_out_0,
  output logic signed [31:0] y_out_1,
  output logic signed [31:0] y_out_2,
  output logic signed [31:0] y_out_3
);

  typedef enum logic [4:0] {
    S_IDLE, S_OFF, S_OFFW, S_RD, S_ARG, S_QA, S_QAW, S_PA, S_PAW, S_QB, S_QBW,
    S_PB, S_PBW, S_M1, S_M2, S_M3, S_M4, S_M5,
    S_G1, S_G2, S_G3, S_G4, S_G5, S_G6, S_G7, S_PTR, S_DONE
  } state_t;

  state_t state;

  logic signed [31:0] feedback_gain, damping, input_scale;
  logic [26:0]        phase_offset;
  logic [30:0]        step_size;
  logic [LEN_W-1:0]   delay_len [NUM_LINES];

  logic signed [31:0] lane_x [NUM_LANES];
  logic signed [31:0] lane_y [NUM_LANES];
  logic signed [31:0] init_x [NUM_LANES];
  logic signed [31:0] drive  [NUM_LANES];
  logic [PTR_W-1:0]   ptr    [NUM_LINES];
  logic [PTR_W:0]     fill   [NUM_LINES];
  logic signed [31:0] out_x  [NUM_LANES];
  logic signed [31:0] out_y  [NUM_LANES];

  logic [LANE_W-1:0]  lane;
  logic [LINE_W-1:0]  line;

  logic signed [39:0] off;
  logic [40:0]        a_reg;
  logic [15:0]        m_reg;
  logic [25:0]        rm;
  logic [20:0]        quo;
  logic [40:0]        acc;
  logic [24:0]        s_reg;
  logic [25:0]        sum;
  logic signed [33:0] fe;
  logic signed [31:0] d_reg;
  logic signed [31:0] nx_reg;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  logic [31:0]        ring [RING_WORDS];
  logic [31:0]        rdata;
  logic [ADDR_W-1:0]  ring_addr;
  logic               ring_we;

  logic               accept, out_free, hit;
  logic signed [31:0] ring_val;
  logic signed [42:0] arg;
  logic [26:0]        diff_a, diff_b;
  logic [4:0]         seg;
  logic [15:0]        frac;
  logic [24:0]        tbl0, tbl1;
  logic [41:0]        s_sum;
  logic [49:0]        sq_sum;
  logic [LEN_W-1:0]   eff_len [NUM_LINES];
  logic [PTR_W:0]     ptr_inc [NUM_LINES];

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign ring_addr = {lane, line, ptr[line]};
  assign ring_we   = (state == S_G6) || (state == S_G7);

  always_comb begin
    hit      = ({1'b0, ptr[line]} < fill[line]);
    ring_val = hit ? $signed(rdata) : init_x[lane];
    arg      = 43'(ring_val) + 43'($signed({1'b0, phase_offset})) + 43'(off)
             + $signed(PI_SHIFTED);
    diff_a   = a_reg[26:0] - prod[26:0];
    diff_b   = {rm[5:0], 21'd0} - prod[26:0];
    seg      = quo[20:16];
    frac     = quo[15:0];
    tbl0     = sine_at({1'b0, seg});
    tbl1     = sine_at(6'({1'b0, seg}) + 6'd1);
    s_sum    = 42'(acc) + 42'(prod[40:0]) + 42'd32768;
    sq_sum   = prod[49:0] + 50'd8388608;
    for (int j = 0; j < NUM_LINES; j++) begin
      if (delay_len[j] == '0) eff_len[j] = LEN_W'(1);
      else if (delay_len[j] > LEN_W'(RING_DEPTH)) eff_len[j] = LEN_W'(RING_DEPTH);
      else eff_len[j] = delay_len[j];
      ptr_inc[j] = {1'b0, ptr[j]} + 1'b1;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_OFF: begin
        mul_a = 33'(input_scale);
        mul_b = 33'(drive[lane]);
      end
      S_QA: begin
        mul_a = $signed({1'b0, a_reg[40:9]});
        mul_b = $signed({1'b0, RECIP_PI});
      end
      S_PA: begin
        mul_a = $signed({17'd0, m_reg});
        mul_b = $signed({6'd0, PI_Q24});
      end
      S_QB: begin
        mul_a = $signed({7'd0, rm});
        mul_b = $signed({1'b0, RECIP_PI});
      end
      S_PB: begin
        mul_a = $signed({12'd0, quo});
        mul_b = $signed({6'd0, PI_Q24});
      end
      S_M1: begin
        mul_a = $signed({8'd0, tbl0});
        mul_b = $signed(33'(17'h10000 - {1'b0, frac}));
      end
      S_M2: begin
        mul_a = $signed({8'd0, tbl1});
        mul_b = $signed({17'd0, frac});
      end
      S_M4: begin
        mul_a = $signed({8'd0, s_reg});
        mul_b = $signed({8'd0, s_reg});
      end
      S_G1: begin
        mul_a = $signed({7'd0, sum});
        mul_b = 33'(feedback_gain);
      end
      S_G2: begin
        mul_a = 33'(damping);
        mul_b = 33'(lane_y[lane]);
      end
      S_G4: begin
        mul_a = $signed({2'd0, step_size});
        mul_b = 33'(d_reg);
      end
      S_G5: begin
        mul_a = $signed({2'd0, step_size});
        mul_b = 33'(lane_x[lane]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ring memory, one read and one write port on a shared address
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[ring_addr] <= nx_reg;
    end
    rdata <= ring[ring_addr];
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      feedback_gain <= '0;
      damping       <= '0;
      phase_offset  <= '0;
      input_scale   <= '0;
      step_size     <= '0;
      lane          <= '0;
      line          <= '0;
      for (int j = 0; j < NUM_LINES; j++) begin
        delay_len[j] <= LEN_W'(1);
        ptr[j]       <= '0;
        fill[j]      <= '0;
      end
      for (int i = 0; i < NUM_LANES; i++) begin
        lane_x[i] <= '0;
        lane_y[i] <= '0;
        init_x[i] <= '0;
      end
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          REG_FEEDBACK_GAIN: feedback_gain <= wr_data;
          REG_DAMPING:       damping       <= wr_data;
          REG_PHASE_OFFSET:  phase_offset  <= wr_data[26:0];
          REG_INPUT_SCALE:   input_scale   <= wr_data;
          REG_STEP_SIZE:     step_size     <= wr_data[30:0];
          REG_DELAY_LEN_0:   delay_len[0]  <= wr_data[LEN_W-1:0];
          REG_DELAY_LEN_1:   delay_len[1]  <= wr_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (req_type == REQ_INIT) begin
              lane_x[0] <= val_a_0;
              lane_x[1] <= val_a_1;
              lane_x[2] <= val_a_2;
              lane_x[3] <= val_a_3;
              init_x[0] <= val_a_0;
              init_x[1] <= val_a_1;
              init_x[2] <= val_a_2;
              init_x[3] <= val_a_3;
              lane_y[0] <= val_b_0;
              lane_y[1] <= val_b_1;
              lane_y[2] <= val_b_2;
              lane_y[3] <= val_b_3;
              for (int j = 0; j < NUM_LINES; j++) begin
                ptr[j]  <= '0;
                fill[j] <= '0;
              end
              state <= S_DONE;
            end else begin
              drive[0] <= val_a_0;
              drive[1] <= val_a_1;
              drive[2] <= val_a_2;
              drive[3] <= val_a_3;
              lane     <= '0;
              state    <= S_OFF;
            end
          end
        end
        S_OFF: begin
          sum   <= '0;
          line  <= '0;
          state <= S_OFFW;
        end
        S_OFFW: begin
          off   <= 40'(rnd24(prod));
          state <= S_RD;
        end
        S_RD: begin
          state <= S_ARG;
        end
        S_ARG: begin
          a_reg <= arg[40:0];
          state <= S_QA;
        end
        S_QA: begin
          state <= S_QAW;
        end
        S_QAW: begin
          m_reg <= prod[63:48];
          state <= S_PA;
        end
        S_PA: begin
          state <= S_PAW;
        end
        S_PAW: begin
          rm    <= (diff_a >= PI_Q24) ? 26'(diff_a - PI_Q24) : diff_a[25:0];
          state <= S_QB;
        end
        S_QB: begin
          state <= S_QBW;
        end
        S_QBW: begin
          quo   <= prod[56:36];
          state <= S_PB;
        end
        S_PB: begin
          state <= S_PBW;
        end
        S_PBW: begin
          if (diff_b >= PI_Q24) begin
            quo <= quo + 21'd1;
          end
          state <= S_M1;
        end
        S_M1: begin
          state <= S_M2;
        end
        S_M2: begin
          acc   <= prod[40:0];
          state <= S_M3;
        end
        S_M3: begin
          s_reg <= s_sum[40:16];
          state <= S_M4;
        end
        S_M4: begin
          state <= S_M5;
        end
        S_M5: begin
          sum <= sum + 26'(sq_sum[49:24]);
          if (line == LINE_W'(NUM_LINES - 1)) begin
            state <= S_G1;
          end else begin
            line  <= line + 1'b1;
            state <= S_RD;
          end
        end
        S_G1: begin
          state <= S_G2;
        end
        S_G2: begin
          fe    <= 34'(rnd24(prod));
          state <= S_G3;
        end
        S_G3: begin
          d_reg <= sat32(-44'(lane_x[lane]) - 44'(rnd24(prod)) + 44'(fe));
          state <= S_G4;
        end
        S_G4: begin
          state <= S_G5;
        end
        S_G5: begin
          nx_reg <= sat32(44'(lane_x[lane]) + 44'(rnd24(prod)));
          line   <= '0;
          state  <= S_G6;
        end
        S_G6: begin
          lane_y[lane] <= sat32(44'(lane_y[lane]) + 44'(rnd24(prod)));
          lane_x[lane] <= nx_reg;
          line         <= 1'b1;
          state        <= S_G7;
        end
        S_G7: begin
          line <= '0;
          if (lane == LANE_W'(NUM_LANES - 1)) begin
            state <= S_PTR;
          end else begin
            lane  <= lane + 1'b1;
            state <= S_OFF;
          end
        end
        S_PTR: begin
          for (int j = 0; j < NUM_LINES; j++) begin
            ptr[j] <= (ptr_inc[j] >= eff_len[j]) ? '0 : ptr_inc[j][PTR_W-1:0];
            if ({1'b0, ptr[j]} == fill[j]) begin
              fill[j] <= fill[j] + 1'b1;
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            for (int i = 0; i < NUM_LANES; i++) begin
              out_x[i] <= lane_x[i];
              out_y[i] <= lane_y[i];
            end
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign x_out_0 = out_x[0];
  assign x_out_1 = out_x[1];
  assign x_out_2 = out_x[2];
  assign x_out_3 = out_x[3];
  assign y_out_0 = out_y[0];
  assign y_out_1 = out_y[1];
  assign y_out_2 = out_y[2];
  assign y_out_3 = out_y[3];

endmodule

// ----- design/dire_checker.sv -----
// dire_checker: port level checks of the delayed ikeda reservoir euler
// step unit, attached by bind; depends on dire_pkg
module dire_checker
  import dire_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               req_type,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] x_out_0,
  input logic signed [31:0] y_out_3
);

  // busy once a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // a new result appears only as the unit goes idle
  a_idle_on_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("result while still busy");

  // a step word taken while no result is valid does not finish straight away
  a_step_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && req_type == REQ_STEP && !out_valid
      |=> !out_valid ##1 !out_valid)
    else $error("step result too early");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(x_out_0) && $stable(y_out_3))
    else $error("stalled result changed");

endmodule

bind delayed_ikeda_reservoir_euler_step_unit dire_checker u_dire_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .req_type  (req_type),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .x_out_0   (x_out_0),
  .y_out_3   (y_out_3)
);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// testbench for delayed_ikeda_reservoir_euler_step_unit: random and directed
// step and init words against a fixed-point predictor held in a scoreboard class
// depends on dire_pkg and the unit under test
module testbench;
  import dire_pkg::*;

  localparam longint CYCLE_LIMIT = 8000000;
  localparam longint PI_VAL = longint'(PI_Q24);
  localparam int HOLD_CYCLES = 3000;

  typedef struct {
    logic        kind;
    logic [31:0] a[4];
    logic [31:0] b[4];
  } lane_word_t;

  typedef struct {
    logic [31:0] x[4];
    logic [31:0] y[4];
  } lane_state_t;

  class ikeda_scoreboard;
    int          gain, damp, scale;
    int unsigned phase, step_h;
    int unsigned ring_len[2];
    int          node_x[4], node_y[4];
    int          ring[4][2][RING_DEPTH];
    int unsigned ring_ptr[2];
    lane_state_t expected_states[$];
    int          mismatches;
    int          checked;
    int          sine_tbl[17] = '{0, 1644455, 3273072, 4870169, 6420363, 7908725,
      9320922, 10643353, 11863283, 12968963, 13949745, 14796184, 15500126,
      16054795, 16454847, 16696429, 16777216};

    function new();
      gain = 0; damp = 0; scale = 0; phase = 0; step_h = 0;
      ring_len = '{1, 1};
      ring_ptr = '{0, 0};
      node_x = '{0, 0, 0, 0};
      node_y = '{0, 0, 0, 0};
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_FEEDBACK_GAIN: gain = data;
        REG_DAMPING: damp = data;
        REG_PHASE_OFFSET: phase = data[26:0];
        REG_INPUT_SCALE: scale = data;
        REG_STEP_SIZE: step_h = data[30:0];
        REG_DELAY_LEN_0: ring_len[0] = data[12:0];
        REG_DELAY_LEN_1: ring_len[1] = data[12:0];
        default: ;
      endcase
    endfunction

    function longint round_q24(longint v);
      return (v + 64'sd8388608) >>> 24;
    endfunction

    function int clip32(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return int'(v);
    endfunction

    function longint tbl(int k);
      return longint'(sine_tbl[k <= 16 ? k : 32 - k]);
    endfunction

    function longint sine_sq(longint arg);
      longint r, q, fr, s;
      int seg;
      r = arg % PI_VAL;
      if (r < 0) r += PI_VAL;
      q = (r << 21) / PI_VAL;
      seg = int'((q >> 16) & 31);
      fr = q & 65535;
      s = (tbl(seg) * (65536 - fr) + tbl(seg + 1) * fr + 32768) >> 16;
      return (s * s + 8388608) >> 24;
    endfunction

    function void note_input(lane_word_t w);
      lane_state_t st;
      longint x, y, off, sum, fe, d;
      int nx;
      int unsigned n, lim;
      if (w.kind == REQ_INIT) begin
        for (int i = 0; i < 4; i++) begin
          node_x[i] = w.a[i];
          node_y[i] = w.b[i];
          for (int j = 0; j < 2; j++)
            for (int k = 0; k < RING_DEPTH; k++) ring[i][j][k] = node_x[i];
        end
        ring_ptr = '{0, 0};
      end else begin
        for (int i = 0; i < 4; i++) begin
          x = node_x[i];
          y = node_y[i];
          off = round_q24(longint'(scale) * longint'(signed'(w.a[i])));
          sum = 0;
          for (int j = 0; j < 2; j++)
            sum += sine_sq(longint'(ring[i][j][ring_ptr[j] % RING_DEPTH]) +
                           longint'(phase) + off);
          fe = round_q24(sum * longint'(gain));
          d = clip32(-x - round_q24(longint'(damp) * y) + fe);
          nx = clip32(x + round_q24(longint'(step_h) * d));
          node_y[i] = clip32(y + round_q24(longint'(step_h) * x));
          node_x[i] = nx;
          for (int j = 0; j < 2; j++) ring[i][j][ring_ptr[j] % RING_DEPTH] = nx;
        end
        for (int j = 0; j < 2; j++) begin
          lim = ring_len[j] < 1 ? 1 : (ring_len[j] > RING_DEPTH ? RING_DEPTH : ring_len[j]);
          n = ring_ptr[j] + 1;
          ring_ptr[j] = (n >= lim) ? 0 : n;
        end
      end
      for (int i = 0; i < 4; i++) begin
        st.x[i] = node_x[i];
        st.y[i] = node_y[i];
      end
      expected_states.push_back(st);
    endfunction

    function void check_result(lane_state_t got);
      lane_state_t want;
      bit bad;
      if (expected_states.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
        return;
      end
      want = expected_states.pop_front();
      checked++;
      bad = 0;
      for (int i = 0; i < 4; i++) begin
        if (got.x[i] !== want.x[i]) begin
          bad = 1;
          if (mismatches < 10)
            $display("word %0d x_out_%0d: expected %h got %h", checked, i, want.x[i], got.x[i]);
        end
        if (got.y[i] !== want.y[i]) begin
          bad = 1;
          if (mismatches < 10)
            $display("word %0d y_out_%0d: expected %h got %h", checked, i, want.y[i], got.y[i]);
        end
      end
      if (bad) mismatches++;
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic wr_en = 0;
  logic [2:0] wr_index = '0;
  logic [31:0] wr_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic req_type = 0;
  logic signed [31:0] val_a_0 = 0, val_a_1 = 0, val_a_2 = 0, val_a_3 = 0;
  logic signed [31:0] val_b_0 = 0, val_b_1 = 0, val_b_2 = 0, val_b_3 = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] x_out_0, x_out_1, x_out_2, x_out_3;
  logic signed [31:0] y_out_0, y_out_1, y_out_2, y_out_3;

  ikeda_scoreboard sb = new();
  longint cycles = 0;
  int hold_requests = 0;
  int burst_left = 0;
  int inits_sent = 0, steps_sent = 0;

  always #5 clk = ~clk;

  delayed_ikeda_reservoir_euler_step_unit DUT (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    lane_state_t r;
    if (!rst && out_valid && !out_stall) begin
      r.x = '{x_out_0, x_out_1, x_out_2, x_out_3};
      r.y = '{y_out_0, y_out_1, y_out_2, y_out_3};
      sb.check_result(r);
    end
  end

  // receiver stall pattern, with long hold-offs on request
  initial begin
    int served, mode;
    served = 0;
    forever begin
      if (hold_requests > served) begin
        served++;
        out_stall <= 1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(16, 200)) begin
        case (mode)
          0: out_stall <= 0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ($urandom_range(0, 1) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      default: return $urandom_range(0, 32'h0c000000) - 32'h06000000;
    endcase
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    wr_en <= 1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic send_word(lane_word_t w);
    in_valid <= 1;
    req_type <= w.kind;
    {val_a_0, val_a_1, val_a_2, val_a_3} <= {w.a[0], w.a[1], w.a[2], w.a[3]};
    {val_b_0, val_b_1, val_b_2, val_b_3} <= {w.b[0], w.b[1], w.b[2], w.b[3]};
    do @(posedge clk); while (in_stall);
    sb.note_input(w);
    if (w.kind == REQ_INIT) inits_sent++; else steps_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      int gap;
      gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 700) : 0;
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    @(posedge clk);
    while (sb.expected_states.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic lane_word_t make_word(logic kind);
    lane_word_t w;
    w.kind = kind;
    for (int i = 0; i < 4; i++) begin
      w.a[i] = rand_q();
      w.b[i] = rand_q();
    end
    return w;
  endfunction

  task automatic load_config(int p);
    logic [31:0] len0, len1;
    len0 = $urandom_range(0, 5) == 0 ? 4096 : $urandom_range(1, 40);
    len1 = $urandom_range(0, 5) == 0 ? 4096 : $urandom_range(1, 40);
    case (p)
      0: begin
        write_reg(REG_FEEDBACK_GAIN, 32'h7fffffff);
        write_reg(REG_DAMPING, 32'h80000000);
        write_reg(REG_PHASE_OFFSET, 105414357);
        write_reg(REG_INPUT_SCALE, 32'h7fffffff);
        write_reg(REG_STEP_SIZE, 32'h7fffffff);
        write_reg(REG_DELAY_LEN_0, 1);
        write_reg(REG_DELAY_LEN_1, 4096);
      end
      1: begin
        write_reg(REG_FEEDBACK_GAIN, 32'h80000000);
        write_reg(REG_DAMPING, 32'h7fffffff);
        write_reg(REG_PHASE_OFFSET, 0);
        write_reg(REG_INPUT_SCALE, 32'h80000000);
        write_reg(REG_STEP_SIZE, 0);
        write_reg(REG_DELAY_LEN_0, 4096);
        write_reg(REG_DELAY_LEN_1, 1);
      end
      default: begin
        // out of range lengths once
        if (p == 2) begin
          len0 = 0;
          len1 = 8191;
        end
        write_reg(REG_FEEDBACK_GAIN, $urandom_range(0, 32'h08000000) - 32'h04000000);
        write_reg(REG_DAMPING, $urandom_range(0, 32'h04000000) - 32'h02000000);
        write_reg(REG_PHASE_OFFSET, $urandom_range(0, 105414357));
        write_reg(REG_INPUT_SCALE, $urandom_range(0, 5) == 0 ? $urandom :
                  $urandom_range(0, 32'h04000000) - 32'h02000000);
        write_reg(REG_STEP_SIZE, $urandom_range(0, 32'h00600000));
        write_reg(REG_DELAY_LEN_0, len0);
        write_reg(REG_DELAY_LEN_1, len1);
      end
    endcase
    wr_en <= 0;
  endtask

  initial begin
    lane_word_t w;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes of every field, both word kinds
    load_config(0);
    w.kind = REQ_INIT;
    w.a = '{32'h7fffffff, 32'h80000000, 0, 32'h01000000};
    w.b = '{32'h80000000, 32'h7fffffff, 32'hffffffff, 0};
    send_word(w);
    for (int n = 0; n < 6; n++) begin
      w.kind = REQ_STEP;
      w.a = '{32'h7fffffff, 32'h80000000, 0, 32'hffffffff};
      w.b = '{32'hffffffff, 0, 32'h7fffffff, 32'h80000000};
      send_word(w);
    end
    wait_idle();
    load_config(1);
    w.kind = REQ_INIT;
    w.a = '{0, 32'hffffffff, 32'h80000000, 32'h7fffffff};
    w.b = '{0, 32'h80000000, 32'h7fffffff, 32'h01000000};
    send_word(w);
    for (int n = 0; n < 6; n++) send_word(make_word(REQ_STEP));
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      load_config(p);
      // a phase without init keeps pointers past a shortened ring
      if (p != 3) send_word(make_word(REQ_INIT));
      for (int n = 0; n < 320; n++) begin
        if (p == 3 && n == 20) hold_requests = hold_requests + 1;
        if (p == 4 && n == 150) wait_idle();
        send_word(make_word($urandom_range(0, 24) == 0 ? REQ_INIT : REQ_STEP));
      end
      wait_idle();
    end

    repeat (50) @(posedge clk);
    $display("covered %0d init and %0d step words over 8 register settings",
             inits_sent, steps_sent);
    $display("%0d result words checked", sb.checked);
    if (sb.mismatches == 0 && sb.expected_states.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
